// ===== src/pafe_pkg.sv =====
// Shared types and constants of the planar arm payload force estimator.
`default_nettype none

package pafe_pkg;

  // Sequencer steps.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TR_PH,
    ST_TR_FOLD,
    ST_TR_X2,
    ST_TR_T1,
    ST_TR_T2,
    ST_TR_SIN,
    ST_GRAV0,
    ST_GRAV1,
    ST_TE,
    ST_JAC,
    ST_DET0,
    ST_DET1,
    ST_SING,
    ST_NUM,
    ST_DIV_SET,
    ST_DIV_CHK,
    ST_DIV_STEP,
    ST_DIV_END,
    ST_PAY,
    ST_NORM0,
    ST_NORM1,
    ST_SQRT,
    ST_DONE
  } state_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_L_SH_OFF = 3'd0;
  localparam logic [2:0] CFG_L_EL_OFF = 3'd1;
  localparam logic [2:0] CFG_R_SH_OFF = 3'd2;
  localparam logic [2:0] CFG_R_EL_OFF = 3'd3;
  localparam logic [2:0] CFG_L_SH_GRV = 3'd4;
  localparam logic [2:0] CFG_L_EL_GRV = 3'd5;
  localparam logic [2:0] CFG_R_SH_GRV = 3'd6;
  localparam logic [2:0] CFG_R_EL_GRV = 3'd7;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  // Shared multiplier geometry.
  localparam int MulW = 27;
  localparam int ProdW = 2 * MulW;
  localparam int AccW = 48;

  // Datapath widths.
  localparam int AngW  = 18;
  localparam int TrigW = 17;
  localparam int TeW   = 25;
  localparam int JacW  = 21;
  localparam int DetW  = 43;
  localparam int NumW  = 47;
  localparam int RemW  = 64;
  localparam int QuoW  = 17;
  localparam int ForceW = 18;
  localparam int SqW   = 35;
  localparam int NormW = 17;
  localparam int CntW  = 32;
  localparam int EvW   = 8;

  // Fixed-point constants.
  localparam logic signed [MulW-1:0] PhaseK   = 27'sd42722830;
  localparam logic signed [MulW-1:0] LinkQ14  = 27'sd4915;
  localparam logic signed [MulW-1:0] SinC1160 = 27'sd1160;
  localparam logic signed [DetW-1:0] DetMin   = 43'sd1099511628;
  localparam logic [QuoW-1:0]        ForceLim = 17'd76800;
  localparam logic [NormW-1:0]       JumpLim  = 17'd12800;
  localparam logic [EvW-1:0]         EventMin = 8'd5;
  localparam logic [EvW-1:0]         EventMax = 8'd255;
  localparam logic [CntW-1:0]        CountMax = 32'hFFFF_FFFF;

  // Iteration counts.
  localparam int TrigLast = 4;
  localparam int QuadLast = 3;
  localparam int DivLast  = 16;
  localparam int SqrtLast = 16;

endpackage

`default_nettype wire

// ===== src/planar_arm_payload_force_estimator.sv =====
// Top level: two-link arm force estimator on one shared multiplier.
`default_nettype none

// Channel   | Dir | Beat contents
// s_axis    | in  | tdata: angles, torques; tuser: side
// m_axis    | out | tdata: forces, payloads, count, boost; tuser: side, valid, singular
// cfg       | in  | write enable, index 0..7, 16-bit value
//
// The step sequencer runs one beat at a time around the shared 27x27 multiplier:
// five sine/cosine evaluations, a 17-step restoring divider run twice (ending early
// when the quotient saturates at once), and a 17-step square root. A singular beat
// ends after the determinant test. Reset clears the configuration, the per-arm state
// and the event count. s_axis_tready_o is high only while no beat is at work; a
// finished result waits in the output register while the next beat is taken, and a
// second finished result holds the sequencer until the first leaves.

module planar_arm_payload_force_estimator #(
  parameter int ARM_COUNT = 2
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [pafe_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire  [pafe_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // shoulder_angle[15:0], elbow_angle[31:16], shoulder_torque[50:32],
  // elbow_torque[69:51], zero fill
  input  wire  [71:0]                     s_axis_tdata_i,
  // side[0]
  input  wire  [0:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  // force_x[17:0], force_y[35:18], shoulder_payload[53:36],
  // elbow_payload[71:54], singular_count[103:72], boost[104], zero fill
  output logic [111:0]                    m_axis_tdata_o,
  // arm_side[0], payload_valid[1], singular[2]
  output logic [2:0]                      m_axis_tuser_o
);

  import pafe_pkg::*;

  localparam int IdxW = (ARM_COUNT > 1) ? $clog2(ARM_COUNT) : 1;

  state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       div_y_q, div_y_d;

  // Configuration registers.
  logic signed [15:0] l_sh_off_q, l_el_off_q, r_sh_off_q, r_el_off_q;
  logic signed [15:0] l_sh_grv_q, l_el_grv_q, r_sh_grv_q, r_el_grv_q;

  // Per-arm state.
  logic signed [ForceW-1:0] last_fx_q [ARM_COUNT];
  logic signed [ForceW-1:0] last_fy_q [ARM_COUNT];
  logic [NormW-1:0]         prev_norm_q [ARM_COUNT];
  logic [CntW-1:0]          sing_cnt_q [ARM_COUNT];
  logic [EvW-1:0]           events_q;

  // Beat registers.
  logic                     side_q;
  logic [IdxW-1:0]          idx_q;
  logic signed [16:0]       qs_q, qe_q;
  logic signed [18:0]       st_q, et_q;
  logic signed [15:0]       sg_q, eg_q;

  // Working registers.
  logic signed [AccW-1:0]   acc_q;
  logic signed [15:0]       s_q, x2_q, t_q;
  logic signed [TrigW-1:0]  trig_q [5];
  logic signed [33:0]       g1_q;
  logic signed [TeW-1:0]    te0_q, te1_q;
  logic signed [JacW-1:0]   j_q [4];
  logic signed [DetW-1:0]   det_q;
  logic signed [NumW-1:0]   numx_q, numy_q;
  logic [RemW-1:0]          rem_q, dsh_q;
  logic [QuoW-1:0]          quo_q;
  logic                     neg_q;
  logic signed [ForceW-1:0] fx_q, fy_q, ps_q, pe_q;
  logic                     sing_q;
  logic [SqW-1:0]           v_q, r_q, bit_q;

  // Output register.
  logic                     out_valid_q;
  logic [111:0]             out_data_q;
  logic [2:0]               out_user_q;

  // Shared multiplier.
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  mul_p;
  assign mul_p = mul_a * mul_b;

  logic in_acc, out_acc, done_go;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = out_valid_q && m_axis_tready_i;
  assign done_go = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Input unpacking.
  logic               in_side;
  logic signed [15:0] in_sa, in_ea;
  logic signed [18:0] in_st, in_et;
  assign in_side = s_axis_tuser_i[0];
  assign in_sa   = s_axis_tdata_i[15:0];
  assign in_ea   = s_axis_tdata_i[31:16];
  assign in_st   = s_axis_tdata_i[50:32];
  assign in_et   = s_axis_tdata_i[69:51];

  // Angle of the current trig evaluation: qs, qs, qe, qe, qs+qe.
  logic signed [AngW-1:0] trig_ang;
  logic                   is_cos;
  always_comb begin
    case (cnt_q[2:0])
      3'd0, 3'd1: trig_ang = AngW'(qs_q);
      3'd2, 3'd3: trig_ang = AngW'(qe_q);
      default:    trig_ang = AngW'(qs_q) + AngW'(qe_q);
    endcase
  end
  assign is_cos = ~cnt_q[0];

  // Phase fold: round to 2^-16 turn, shift for cosine, fold to +-quarter turn.
  logic [AccW-1:0]    ph_sum;
  logic [15:0]        ph;
  logic signed [16:0] s_raw, s_fold;
  always_comb begin
    ph_sum = acc_q + AccW'(1 << 23);
    ph     = ph_sum[39:24] + (is_cos ? 16'd16384 : 16'd0);
    s_raw  = 17'(signed'(ph));
    if (s_raw > 17'sd16384) begin
      s_fold = 17'sd32768 - s_raw;
    end else if (s_raw < -17'sd16384) begin
      s_fold = -17'sd32768 - s_raw;
    end else begin
      s_fold = s_raw;
    end
  end

  // Jacobian operand for the current entry.
  logic signed [AngW-1:0] jac_in;
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    jac_in = -(AngW'(trig_q[1]) + AngW'(trig_q[3]));
      2'd1:    jac_in = AngW'(trig_q[0]) + AngW'(trig_q[2]);
      2'd2:    jac_in = -AngW'(trig_q[3]);
      default: jac_in = AngW'(trig_q[2]);
    endcase
  end

  // Multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_TR_PH:  begin mul_a = MulW'(trig_ang); mul_b = PhaseK; end
      ST_TR_X2:  begin mul_a = MulW'(s_q);      mul_b = MulW'(s_q); end
      ST_TR_T1:  begin mul_a = MulW'(x2_q);     mul_b = SinC1160; end
      ST_TR_T2:  begin mul_a = MulW'(x2_q);     mul_b = MulW'(t_q); end
      ST_TR_SIN: begin mul_a = MulW'(s_q);      mul_b = MulW'(t_q); end
      ST_GRAV0:  begin mul_a = MulW'(sg_q);     mul_b = MulW'(trig_q[0]); end
      ST_GRAV1:  begin mul_a = MulW'(eg_q);     mul_b = MulW'(trig_q[4]); end
      ST_JAC:    begin mul_a = MulW'(jac_in);   mul_b = LinkQ14; end
      ST_DET0:   begin mul_a = MulW'(j_q[0]);   mul_b = MulW'(j_q[3]); end
      ST_DET1:   begin mul_a = MulW'(j_q[1]);   mul_b = MulW'(j_q[2]); end
      ST_NUM: begin
        case (cnt_q[1:0])
          2'd0:    begin mul_a = MulW'(j_q[3]); mul_b = MulW'(te0_q); end
          2'd1:    begin mul_a = MulW'(j_q[1]); mul_b = MulW'(te1_q); end
          2'd2:    begin mul_a = MulW'(j_q[0]); mul_b = MulW'(te1_q); end
          default: begin mul_a = MulW'(j_q[2]); mul_b = MulW'(te0_q); end
        endcase
      end
      ST_PAY: begin
        case (cnt_q[1:0])
          2'd0:    begin mul_a = MulW'(j_q[0]); mul_b = MulW'(fx_q); end
          2'd1:    begin mul_a = MulW'(j_q[1]); mul_b = MulW'(fy_q); end
          2'd2:    begin mul_a = MulW'(j_q[2]); mul_b = MulW'(fx_q); end
          default: begin mul_a = MulW'(j_q[3]); mul_b = MulW'(fy_q); end
        endcase
      end
      ST_NORM0:  begin mul_a = MulW'(fx_q);     mul_b = MulW'(fx_q); end
      ST_NORM1:  begin mul_a = MulW'(fy_q);     mul_b = MulW'(fy_q); end
      default:   begin mul_a = '0;              mul_b = '0; end
    endcase
  end

  // Accumulate and difference terms.
  logic signed [AccW-1:0] acc_add, acc_sub;
  assign acc_add = acc_q + AccW'(mul_p);
  assign acc_sub = acc_q - AccW'(mul_p);

  // Payload rounding and saturation.
  logic signed [AccW-1:0] pay_rnd;
  logic signed [ForceW-1:0] pay_sat;
  always_comb begin
    pay_rnd = (acc_add + AccW'(1 << 19)) >>> 20;
    if (pay_rnd > AccW'(131071)) begin
      pay_sat = 18'sd131071;
    end else if (pay_rnd < -AccW'(131072)) begin
      pay_sat = -18'sd131072;
    end else begin
      pay_sat = ForceW'(pay_rnd);
    end
  end

  // Divider setup and quotient finish.
  logic signed [NumW-1:0] div_num;
  logic [NumW-1:0]        num_abs;
  logic [DetW-1:0]        det_abs;
  logic [QuoW-1:0]        quo_cap;
  logic signed [ForceW-1:0] force_res;
  always_comb begin
    div_num   = div_y_q ? numy_q : numx_q;
    num_abs   = div_num[NumW-1] ? NumW'(-div_num) : NumW'(div_num);
    det_abs   = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);
    quo_cap   = (quo_q > ForceLim) ? ForceLim : quo_q;
    force_res = neg_q ? -ForceW'(quo_cap) : ForceW'(quo_cap);
  end

  // Square root step.
  logic [SqW-1:0] rb;
  assign rb = r_q + bit_q;

  // Singular test.
  logic is_sing;
  assign is_sing = (det_q > -DetMin) && (det_q < DetMin);

  // Final bookkeeping.
  logic [NormW-1:0] norm, prev, diff;
  logic             jump, boost;
  logic [EvW-1:0]   ev_new;
  logic [CntW-1:0]  cnt_new;
  always_comb begin
    norm    = r_q[NormW-1:0];
    prev    = prev_norm_q[idx_q];
    diff    = (norm > prev) ? norm - prev : prev - norm;
    jump    = diff > JumpLim;
    ev_new  = (jump && events_q != EventMax) ? events_q + 8'd1 : events_q;
    boost   = jump && (ev_new >= EventMin);
    cnt_new = (sing_cnt_q[idx_q] == CountMax) ? CountMax : sing_cnt_q[idx_q] + 32'd1;
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      div_y_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      div_y_q <= div_y_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    div_y_d = div_y_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_TR_PH;
          cnt_d   = '0;
        end
      end
      ST_TR_PH:   state_d = ST_TR_FOLD;
      ST_TR_FOLD: state_d = ST_TR_X2;
      ST_TR_X2:   state_d = ST_TR_T1;
      ST_TR_T1:   state_d = ST_TR_T2;
      ST_TR_T2:   state_d = ST_TR_SIN;
      ST_TR_SIN: begin
        if (cnt_q == 5'(TrigLast)) begin
          state_d = ST_GRAV0;
          cnt_d   = '0;
        end else begin
          state_d = ST_TR_PH;
          cnt_d   = cnt_q + 5'd1;
        end
      end
      ST_GRAV0: state_d = ST_GRAV1;
      ST_GRAV1: state_d = ST_TE;
      ST_TE:    state_d = ST_JAC;
      ST_JAC: begin
        if (cnt_q == 5'(QuadLast)) begin
          state_d = ST_DET0;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_DET0: state_d = ST_DET1;
      ST_DET1: state_d = ST_SING;
      ST_SING: begin
        state_d = is_sing ? ST_DONE : ST_NUM;
        cnt_d   = '0;
      end
      ST_NUM: begin
        if (cnt_q == 5'(QuadLast)) begin
          state_d = ST_DIV_SET;
          cnt_d   = '0;
          div_y_d = 1'b0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_DIV_SET: state_d = ST_DIV_CHK;
      ST_DIV_CHK: begin
        state_d = (rem_q >= dsh_q) ? ST_DIV_END : ST_DIV_STEP;
        cnt_d   = '0;
      end
      ST_DIV_STEP: begin
        if (cnt_q == 5'(DivLast)) begin
          state_d = ST_DIV_END;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_DIV_END: begin
        if (div_y_q) begin
          state_d = ST_PAY;
          cnt_d   = '0;
        end else begin
          state_d = ST_DIV_SET;
          div_y_d = 1'b1;
        end
      end
      ST_PAY: begin
        if (cnt_q == 5'(QuadLast)) begin
          state_d = ST_NORM0;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_NORM0: state_d = ST_NORM1;
      ST_NORM1: begin
        state_d = ST_SQRT;
        cnt_d   = '0;
      end
      ST_SQRT: begin
        if (cnt_q == 5'(SqrtLast)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Configuration, per-arm state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_sh_off_q <= '0;
      l_el_off_q <= '0;
      r_sh_off_q <= '0;
      r_el_off_q <= '0;
      l_sh_grv_q <= '0;
      l_el_grv_q <= '0;
      r_sh_grv_q <= '0;
      r_el_grv_q <= '0;
      for (int i = 0; i < ARM_COUNT; i++) begin
        last_fx_q[i]   <= '0;
        last_fy_q[i]   <= '0;
        prev_norm_q[i] <= '0;
        sing_cnt_q[i]  <= '0;
      end
      events_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_L_SH_OFF: l_sh_off_q <= cfg_wdata_i;
          CFG_L_EL_OFF: l_el_off_q <= cfg_wdata_i;
          CFG_R_SH_OFF: r_sh_off_q <= cfg_wdata_i;
          CFG_R_EL_OFF: r_el_off_q <= cfg_wdata_i;
          CFG_L_SH_GRV: l_sh_grv_q <= cfg_wdata_i;
          CFG_L_EL_GRV: l_el_grv_q <= cfg_wdata_i;
          CFG_R_SH_GRV: r_sh_grv_q <= cfg_wdata_i;
          CFG_R_EL_GRV: r_el_grv_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_DONE && done_go) begin
        out_valid_q <= 1'b1;
        if (sing_q) begin
          sing_cnt_q[idx_q] <= cnt_new;
        end else begin
          last_fx_q[idx_q]   <= fx_q;
          last_fy_q[idx_q]   <= fy_q;
          prev_norm_q[idx_q] <= norm;
          events_q           <= ev_new;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // Hold the beat and pick the arm's registers.
          side_q <= in_side;
          idx_q  <= (ARM_COUNT > 1) ? IdxW'(in_side) : '0;
          qs_q   <= 17'(in_sa) + 17'(in_side ? r_sh_off_q : l_sh_off_q);
          qe_q   <= 17'(in_ea) + 17'(in_side ? r_el_off_q : l_el_off_q);
          st_q   <= in_st;
          et_q   <= in_et;
          sg_q   <= in_side ? r_sh_grv_q : l_sh_grv_q;
          eg_q   <= in_side ? r_el_grv_q : l_el_grv_q;
        end
      end
      ST_TR_PH:   acc_q <= AccW'(mul_p);
      ST_TR_FOLD: s_q   <= 16'(s_fold);
      ST_TR_X2:   x2_q  <= 16'(mul_p >>> 14);
      ST_TR_T1:   t_q   <= 16'sd10512 - 16'(mul_p >>> 14);
      ST_TR_T2:   t_q   <= 16'sd25736 - 16'(mul_p >>> 14);
      ST_TR_SIN:  trig_q[cnt_q[2:0]] <= TrigW'(mul_p >>> 14);
      ST_GRAV0:   acc_q <= AccW'(mul_p);
      ST_GRAV1: begin
        acc_q <= acc_add;
        g1_q  <= 34'(mul_p);
      end
      ST_TE: begin
        te0_q <= (TeW'(st_q) <<< 4) - TeW'(acc_q >>> 10);
        te1_q <= (TeW'(et_q) <<< 4) - TeW'(g1_q >>> 10);
      end
      ST_JAC:  j_q[cnt_q[1:0]] <= JacW'(mul_p >>> 8);
      ST_DET0: acc_q <= AccW'(mul_p);
      ST_DET1: det_q <= DetW'(acc_sub);
      ST_SING: sing_q <= is_sing;
      ST_NUM: begin
        case (cnt_q[1:0])
          2'd1:    numx_q <= NumW'(acc_sub);
          2'd3:    numy_q <= NumW'(acc_sub);
          default: acc_q  <= AccW'(mul_p);
        endcase
      end
      ST_DIV_SET: begin
        rem_q <= RemW'(num_abs) << 16;
        dsh_q <= RemW'(det_abs) << 17;
        neg_q <= div_num[NumW-1] ^ det_q[DetW-1];
        quo_q <= '0;
      end
      ST_DIV_CHK: begin
        // Quotient of 2^17 or more: saturate at once.
        if (rem_q >= dsh_q) begin
          quo_q <= ForceLim;
        end
        dsh_q <= dsh_q >> 1;
      end
      ST_DIV_STEP: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[QuoW-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[QuoW-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      ST_DIV_END: begin
        if (div_y_q) begin
          fy_q <= force_res;
        end else begin
          fx_q <= force_res;
        end
      end
      ST_PAY: begin
        case (cnt_q[1:0])
          2'd1:    ps_q  <= pay_sat;
          2'd3:    pe_q  <= pay_sat;
          default: acc_q <= AccW'(mul_p);
        endcase
      end
      ST_NORM0: acc_q <= AccW'(mul_p);
      ST_NORM1: begin
        v_q   <= SqW'(acc_add);
        r_q   <= '0;
        bit_q <= SqW'(64'd1 << 32);
      end
      ST_SQRT: begin
        if (v_q >= rb) begin
          v_q <= v_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_DONE: begin
        if (done_go) begin
          if (sing_q) begin
            // Drop the payloads and return the last valid force.
            out_data_q <= {7'd0, 1'b0, cnt_new, 18'd0, 18'd0,
                           last_fy_q[idx_q], last_fx_q[idx_q]};
            out_user_q <= {1'b1, 1'b0, side_q};
          end else begin
            out_data_q <= {7'd0, boost, sing_cnt_q[idx_q], pe_q, ps_q, fy_q, fx_q};
            out_user_q <= {1'b0, 1'b1, side_q};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
